### rtl/mfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types, codes and the CRC-8 step for the modem frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

   // Framing bytes and frame directions
   localparam logic [7:0] SYNC1_BYTE      = 8'hAA;
   localparam logic [7:0] SYNC2_BYTE      = 8'h55;
   localparam logic [7:0] DIR_DATA        = 8'h02;
   localparam logic [7:0] DIR_STATUS      = 8'h04;
   localparam logic [7:0] STATUS_HDR0     = 8'h01;
   localparam logic [7:0] STATUS_HDR1     = 8'h00;
   localparam logic [7:0] MODE_LONG_RANGE = 8'h02;
   localparam logic [7:0] CRC_POLY        = 8'h8C;

   // Frame length limits
   localparam logic [8:0] DATA_MIN_LEN    = 9'd7;
   localparam logic [8:0] STATUS_MIN_LEN  = 9'd10;
   localparam logic [8:0] POWER_MIN_LEN   = 9'd11;
   localparam logic [8:0] PEERS_MIN_LEN   = 9'd12;

   // Body byte positions
   localparam logic [8:0] POS_SRC_END     = 9'd6;   // source MAC is positions 0 to 5
   localparam logic [8:0] POS_RSSI        = 9'd6;
   localparam logic [8:0] POS_DATA_FIRST  = 9'd7;
   localparam logic [8:0] POS_HDR0        = 9'd0;
   localparam logic [8:0] POS_HDR1        = 9'd1;
   localparam logic [8:0] POS_MAC_END     = 9'd8;   // status MAC is positions 2 to 7
   localparam logic [8:0] POS_MODE        = 9'd8;
   localparam logic [8:0] POS_CHANNEL     = 9'd9;
   localparam logic [8:0] POS_POWER       = 9'd10;
   localparam logic [8:0] POS_PEERS       = 9'd11;

   // Reset values of the committed status
   localparam logic [7:0] RESET_CHANNEL   = 8'd1;
   localparam logic [7:0] RESET_POWER     = 8'd84;

   typedef enum logic [1:0] {
      EV_DATA    = 2'd0,
      EV_END     = 2'd1,
      EV_STATUS  = 2'd2,
      EV_IGNORED = 2'd3
   } event_type;

   typedef enum logic [6:0] {
      PH_SYNC1 = 7'b0000001,
      PH_SYNC2 = 7'b0000010,
      PH_DIR   = 7'b0000100,
      PH_LENH  = 7'b0001000,
      PH_LENL  = 7'b0010000,
      PH_BODY  = 7'b0100000,
      PH_CRC   = 7'b1000000
   } phase_type;

   typedef struct packed {
      event_type          event_res;
      logic [7:0]         data_byte;
      logic               last;
      logic [47:0]        src_mac;
      logic signed [7:0]  rssi;
      logic [8:0]         data_length;
      logic               crc_ok;
      logic [47:0]        modem_mac;
      logic               long_range;
      logic [7:0]         radio_channel;
      logic [7:0]         tx_power;
      logic [7:0]         peer_count;
   } result_type;

   // One byte of the reflected CRC-8, bit serial unrolled
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      logic       fb;
      c = crc;
      d = b;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[0];
         c  = {1'b0, c[7:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

endpackage

### rtl/modem_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_frame_receiver
// Byte-serial receiver for sync-framed modem data and status frames.
// ----------------------------------------------------------------------------
// One received byte per clock is taken on the req_ channel. Each byte is
// parsed in the cycle it is accepted and any result lands in a single result
// register, so a byte can be accepted every clock and its result is offered
// on the rsp_ channel the next cycle; the link stalls only while a result
// sits in that register and rsp_ready is low. Data frames emit one
// result per data byte plus an end result on the CRC byte; status frames and
// all other accepted frames give one result on the CRC byte. crc_ok reports
// the reflected CRC-8 (poly 0x8C, init 0) check but never drops a frame. The
// committed modem status is carried on every result.
module modem_frame_receiver #(
   parameter int MAX_PAYLOAD = 300
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_res,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_last,
   output logic [47:0]        rsp_src_mac,
   output logic signed [7:0]  rsp_rssi,
   output logic [8:0]         rsp_data_length,
   output logic               rsp_crc_ok,
   output logic [47:0]        rsp_modem_mac,
   output logic               rsp_long_range,
   output logic [7:0]         rsp_radio_channel,
   output logic [7:0]         rsp_tx_power,
   output logic [7:0]         rsp_peer_count
);
   import mfr_pkg::*;

   logic       accept;
   logic       produce;
   result_type result;
   result_type rsp_data;

   assign accept = req_valid && req_ready;

   mfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .produce (produce),
      .result  (result)
   );

   mfr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (produce),
      .load_data (result),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Break out the result word
   assign rsp_event_res     = rsp_data.event_res;
   assign rsp_data_byte     = rsp_data.data_byte;
   assign rsp_last          = rsp_data.last;
   assign rsp_src_mac       = rsp_data.src_mac;
   assign rsp_rssi          = rsp_data.rssi;
   assign rsp_data_length   = rsp_data.data_length;
   assign rsp_crc_ok        = rsp_data.crc_ok;
   assign rsp_modem_mac     = rsp_data.modem_mac;
   assign rsp_long_range    = rsp_data.long_range;
   assign rsp_radio_channel = rsp_data.radio_channel;
   assign rsp_tx_power      = rsp_data.tx_power;
   assign rsp_peer_count    = rsp_data.peer_count;

`ifndef SYNTHESIS
   // An empty result register never blocks the link
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty result register");

   // A result is produced only for an accepted byte
   a_produce_on_accept: assert property (@(posedge clock) disable iff (reset)
      produce |-> accept)
      else $error("result produced without an accepted byte");

   // Every result except a data byte ends a frame
   a_last_matches_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_event_res != EV_DATA)))
      else $error("last flag disagrees with event");

   // Data length and CRC flag only on frame-end results
   a_data_fields_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_DATA) |-> !rsp_crc_ok && (rsp_data_length == 9'd0))
      else $error("frame-end fields set on a data byte result");
`endif

endmodule

### rtl/mfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_parser
// Frame parser: sync hunt, header, body capture, CRC and status commit.
// ----------------------------------------------------------------------------
module mfr_parser #(
   parameter int MAX_PAYLOAD = 300
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output logic                   produce,
   output mfr_pkg::result_type    result
);
   import mfr_pkg::*;

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [7:0]  dir_ff, dir_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [8:0]  len_ff, len_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [7:0]  rssi_ff, rssi_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [47:0] st_mac_ff, st_mac_in;
   logic [7:0]  st_mode_ff, st_mode_in;
   logic [7:0]  st_chan_ff, st_chan_in;
   logic [7:0]  st_power_ff, st_power_in;
   logic [7:0]  st_peers_ff, st_peers_in;
   logic [47:0] mac_ff, mac_in;
   logic        long_ff, long_in;
   logic [7:0]  chan_ff, chan_in;
   logic [7:0]  power_ff, power_in;
   logic [7:0]  peers_ff, peers_in;

   logic [15:0] len_word;
   logic [8:0]  pos_inc;
   logic        is_data;
   logic        is_status;
   logic        crc_match;
   event_type   ev;
   logic        with_src;
   logic        ev_last;

   assign len_word  = {len_high_ff, rx_byte};
   assign pos_inc   = pos_ff + 9'd1;
   assign is_data   = (dir_ff == DIR_DATA) && (len_ff >= DATA_MIN_LEN);
   assign is_status = (dir_ff == DIR_STATUS) && (len_ff >= STATUS_MIN_LEN) && hdr_ok_ff;
   assign crc_match = (rx_byte == crc_ff);

   // Next state and the result of the current byte
   always_comb begin
      phase_in    = phase_ff;
      dir_in      = dir_ff;
      len_high_in = len_high_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      src_mac_in  = src_mac_ff;
      rssi_in     = rssi_ff;
      hdr_ok_in   = hdr_ok_ff;
      st_mac_in   = st_mac_ff;
      st_mode_in  = st_mode_ff;
      st_chan_in  = st_chan_ff;
      st_power_in = st_power_ff;
      st_peers_in = st_peers_ff;
      mac_in      = mac_ff;
      long_in     = long_ff;
      chan_in     = chan_ff;
      power_in    = power_ff;
      peers_in    = peers_ff;
      produce     = 1'b0;
      ev          = EV_IGNORED;
      with_src    = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == SYNC1_BYTE) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == SYNC2_BYTE) ? PH_DIR : PH_SYNC1;
            end
            PH_DIR: begin
               dir_in   = rx_byte;
               phase_in = PH_LENH;
            end
            PH_LENH: begin
               len_high_in = rx_byte;
               phase_in    = PH_LENL;
            end
            PH_LENL: begin
               // drop frames of zero or oversize length
               if (len_word == 16'd0 || len_word > MaxLen) begin
                  phase_in = PH_SYNC1;
               end else begin
                  len_in     = len_word[8:0];
                  pos_in     = '0;
                  crc_in     = '0;
                  hdr_ok_in  = 1'b0;
                  src_mac_in = '0;
                  rssi_in    = '0;
                  phase_in   = PH_BODY;
               end
            end
            PH_BODY: begin
               crc_in = crc8_step(crc_ff, rx_byte);
               // data frame view
               if (pos_ff < POS_SRC_END) begin
                  src_mac_in = {src_mac_ff[39:0], rx_byte};
               end else if (pos_ff == POS_RSSI) begin
                  rssi_in = rx_byte;
               end
               // status frame view
               if (pos_ff == POS_HDR0) begin
                  hdr_ok_in = (rx_byte == STATUS_HDR0);
               end else if (pos_ff == POS_HDR1) begin
                  hdr_ok_in = hdr_ok_ff && (rx_byte == STATUS_HDR1);
               end else if (pos_ff < POS_MAC_END) begin
                  st_mac_in = {st_mac_ff[39:0], rx_byte};
               end else if (pos_ff == POS_MODE) begin
                  st_mode_in = rx_byte;
               end else if (pos_ff == POS_CHANNEL) begin
                  st_chan_in = rx_byte;
               end else if (pos_ff == POS_POWER) begin
                  st_power_in = rx_byte;
               end else if (pos_ff == POS_PEERS) begin
                  st_peers_in = rx_byte;
               end
               pos_in = pos_inc;
               if (pos_inc >= len_ff) begin
                  phase_in = PH_CRC;
               end
               if (is_data && pos_ff >= POS_DATA_FIRST) begin
                  produce  = 1'b1;
                  ev       = EV_DATA;
                  with_src = 1'b1;
               end
            end
            PH_CRC: begin
               phase_in = PH_SYNC1;
               produce  = 1'b1;
               if (is_data) begin
                  ev       = EV_END;
                  with_src = 1'b1;
               end else if (is_status) begin
                  ev      = EV_STATUS;
                  mac_in  = st_mac_ff;
                  long_in = (st_mode_ff == MODE_LONG_RANGE);
                  chan_in = st_chan_ff;
                  if (len_ff >= POWER_MIN_LEN) begin
                     power_in = st_power_ff;
                  end
                  if (len_ff >= PEERS_MIN_LEN) begin
                     peers_in = st_peers_ff;
                  end
               end
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   // Assemble the result word
   assign ev_last = (ev != EV_DATA);
   always_comb begin
      result.event_res     = ev;
      result.data_byte     = (ev == EV_DATA) ? rx_byte : 8'd0;
      result.last          = ev_last;
      result.src_mac       = with_src ? src_mac_in : 48'd0;
      result.rssi          = with_src ? $signed(rssi_in) : 8'sd0;
      result.data_length   = (ev == EV_END) ? (len_ff - DATA_MIN_LEN) : 9'd0;
      result.crc_ok        = ev_last && crc_match;
      result.modem_mac     = mac_in;
      result.long_range    = long_in;
      result.radio_channel = chan_in;
      result.tx_power      = power_in;
      result.peer_count    = peers_in;
   end

   // Control and committed status
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         mac_ff   <= '0;
         long_ff  <= 1'b0;
         chan_ff  <= RESET_CHANNEL;
         power_ff <= RESET_POWER;
         peers_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         mac_ff   <= mac_in;
         long_ff  <= long_in;
         chan_ff  <= chan_in;
         power_ff <= power_in;
         peers_ff <= peers_in;
      end
   end

   // Frame context and shadow fields, set before use in every frame
   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      len_high_ff <= len_high_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      crc_ff      <= crc_in;
      src_mac_ff  <= src_mac_in;
      rssi_ff     <= rssi_in;
      hdr_ok_ff   <= hdr_ok_in;
      st_mac_ff   <= st_mac_in;
      st_mode_ff  <= st_mode_in;
      st_chan_ff  <= st_chan_in;
      st_power_ff <= st_power_in;
      st_peers_ff <= st_peers_in;
   end

endmodule

### rtl/mfr_rsp_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_rsp_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module mfr_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  mfr_pkg::result_type    load_data,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mfr_pkg::result_type    rsp_data
);
   import mfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Take a new result whenever the held one leaves or none is held
   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### verif/modem_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_frame_receiver_tb
// Drives the receiver with byte streams of sync-framed data, status and
// other frames, plus broken syncs, bad lengths and line noise. A frame
// tracker follows the byte stream, predicts every result and checks the
// results, one field at a time, in order of arrival.
// ----------------------------------------------------------------------------
module modem_frame_receiver_tb;
   import mfr_pkg::*;

   localparam int MAX_PAYLOAD_TB = 300;
   localparam int BYTE_TARGET    = 1450;
   localparam int IDLE_PERCENT   = 12;
   localparam int CALM_FIRST     = 500;
   localparam int CALM_LAST      = 800;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 200000;

   typedef logic [7:0] byte_q_t[$];

   // Tracks the frame parser and the committed status, holds the results due
   class frame_tracker;
      phase_type   phase;
      logic [7:0]  direction;
      logic [7:0]  length_high;
      logic [8:0]  frame_len;
      logic [8:0]  position;
      logic [7:0]  payload_crc;
      logic [47:0] source_mac;
      logic [7:0]  source_rssi;
      bit          header_ok;
      logic [47:0] status_mac;
      logic [7:0]  status_mode;
      logic [7:0]  status_channel;
      logic [7:0]  status_power;
      logic [7:0]  status_peers;
      logic [47:0] modem_mac;
      bit          long_range;
      logic [7:0]  channel;
      logic [7:0]  power;
      logic [7:0]  peers;
      result_type  due_results[$];
      int          mismatches;

      function new();
         phase          = PH_SYNC1;
         direction      = '0;
         length_high    = '0;
         frame_len      = '0;
         position       = '0;
         payload_crc    = '0;
         source_mac     = '0;
         source_rssi    = '0;
         header_ok      = 1'b0;
         status_mac     = '0;
         status_mode    = '0;
         status_channel = '0;
         status_power   = '0;
         status_peers   = '0;
         modem_mac      = '0;
         long_range     = 1'b0;
         channel        = RESET_CHANNEL;
         power          = RESET_POWER;
         peers          = '0;
         mismatches     = 0;
      endfunction

      // Reflected CRC-8, one bit per pass, LSB first
      function logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] data);
         logic [7:0] c;
         logic [7:0] d;
         c = acc;
         d = data;
         for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
               c = (c >> 1) ^ CRC_POLY;
            end else begin
               c = c >> 1;
            end
            d = d >> 1;
         end
         return c;
      endfunction

      function bit data_frame();
         return direction == DIR_DATA && frame_len >= DATA_MIN_LEN;
      endfunction

      // Advance the parser by one accepted byte and queue any result it causes
      function void take_byte(input logic [7:0] b);
         result_type  r;
         logic [15:0] full_len;
         logic [8:0]  at;
         bit          emit;
         r    = '0;
         emit = 1'b0;
         case (phase)
            PH_SYNC1: begin
               if (b == SYNC1_BYTE) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
               phase = (b == SYNC2_BYTE) ? PH_DIR : PH_SYNC1;
            end
            PH_DIR: begin
               direction = b;
               phase     = PH_LENH;
            end
            PH_LENH: begin
               length_high = b;
               phase       = PH_LENL;
            end
            PH_LENL: begin
               full_len = {length_high, b};
               if (full_len == 16'd0 || full_len > MAX_PAYLOAD_TB) begin
                  phase = PH_SYNC1;
               end else begin
                  frame_len   = full_len[8:0];
                  position    = '0;
                  payload_crc = '0;
                  header_ok   = 1'b0;
                  source_mac  = '0;
                  source_rssi = '0;
                  phase       = PH_BODY;
               end
            end
            PH_BODY: begin
               at          = position;
               payload_crc = fold_crc(payload_crc, b);
               if (at < POS_SRC_END) source_mac = {source_mac[39:0], b};
               else if (at == POS_RSSI) source_rssi = b;
               if (at == POS_HDR0) header_ok = (b == STATUS_HDR0);
               else if (at == POS_HDR1) header_ok = header_ok && (b == STATUS_HDR1);
               else if (at < POS_MAC_END) status_mac = {status_mac[39:0], b};
               else if (at == POS_MODE) status_mode = b;
               else if (at == POS_CHANNEL) status_channel = b;
               else if (at == POS_POWER) status_power = b;
               else if (at == POS_PEERS) status_peers = b;
               position = at + 9'd1;
               if (position >= frame_len) phase = PH_CRC;
               if (data_frame() && at >= POS_DATA_FIRST) begin
                  r.event_res = EV_DATA;
                  r.data_byte = b;
                  r.src_mac   = source_mac;
                  r.rssi      = source_rssi;
                  emit        = 1'b1;
               end
            end
            PH_CRC: begin
               phase    = PH_SYNC1;
               r.last   = 1'b1;
               r.crc_ok = (b == payload_crc);
               emit     = 1'b1;
               if (data_frame()) begin
                  r.event_res   = EV_END;
                  r.src_mac     = source_mac;
                  r.rssi        = source_rssi;
                  r.data_length = frame_len - DATA_MIN_LEN;
               end else if (direction == DIR_STATUS && frame_len >= STATUS_MIN_LEN
                            && header_ok) begin
                  // commit the status; frames too short to carry power or peers keep the old values
                  modem_mac  = status_mac;
                  long_range = (status_mode == MODE_LONG_RANGE);
                  channel    = status_channel;
                  if (frame_len >= POWER_MIN_LEN) power = status_power;
                  if (frame_len >= PEERS_MIN_LEN) peers = status_peers;
                  r.event_res = EV_STATUS;
               end else begin
                  r.event_res = EV_IGNORED;
               end
            end
            default: begin
               phase = PH_SYNC1;
            end
         endcase
         if (emit) begin
            r.modem_mac     = modem_mac;
            r.long_range    = long_range;
            r.radio_channel = channel;
            r.tx_power      = power;
            r.peer_count    = peers;
            due_results.push_back(r);
         end
      endfunction

      function void report(input string what, input logic [63:0] want_v,
                           input logic [63:0] got_v);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what,
                     want_v, got_v);
         end
      endfunction

      // Compare one transferred result with the oldest one due
      function void check_result(input result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            report("unexpected result, event_res", '0, got.event_res);
            return;
         end
         want = due_results.pop_front();
         if (got.event_res !== want.event_res)
            report("event_res", want.event_res, got.event_res);
         if (got.data_byte !== want.data_byte)
            report("data_byte", want.data_byte, got.data_byte);
         if (got.last !== want.last)
            report("last", want.last, got.last);
         if (got.src_mac !== want.src_mac)
            report("src_mac", want.src_mac, got.src_mac);
         if (got.rssi !== want.rssi)
            report("rssi", {56'd0, want.rssi}, {56'd0, got.rssi});
         if (got.data_length !== want.data_length)
            report("data_length", want.data_length, got.data_length);
         if (got.crc_ok !== want.crc_ok)
            report("crc_ok", want.crc_ok, got.crc_ok);
         if (got.modem_mac !== want.modem_mac)
            report("modem_mac", want.modem_mac, got.modem_mac);
         if (got.long_range !== want.long_range)
            report("long_range", want.long_range, got.long_range);
         if (got.radio_channel !== want.radio_channel)
            report("radio_channel", want.radio_channel, got.radio_channel);
         if (got.tx_power !== want.tx_power)
            report("tx_power", want.tx_power, got.tx_power);
         if (got.peer_count !== want.peer_count)
            report("peer_count", want.peer_count, got.peer_count);
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_event_res;
   logic [7:0]         rsp_data_byte;
   logic               rsp_last;
   logic [47:0]        rsp_src_mac;
   logic signed [7:0]  rsp_rssi;
   logic [8:0]         rsp_data_length;
   logic               rsp_crc_ok;
   logic [47:0]        rsp_modem_mac;
   logic               rsp_long_range;
   logic [7:0]         rsp_radio_channel;
   logic [7:0]         rsp_tx_power;
   logic [7:0]         rsp_peer_count;

   frame_tracker tracker = new();
   int           sent_bytes = 0;
   bit           calm = 1'b0;
   int           cycle_count = 0;

   modem_frame_receiver #(
      .MAX_PAYLOAD(MAX_PAYLOAD_TB)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_data_byte(rsp_data_byte),
      .rsp_last(rsp_last),
      .rsp_src_mac(rsp_src_mac),
      .rsp_rssi(rsp_rssi),
      .rsp_data_length(rsp_data_length),
      .rsp_crc_ok(rsp_crc_ok),
      .rsp_modem_mac(rsp_modem_mac),
      .rsp_long_range(rsp_long_range),
      .rsp_radio_channel(rsp_radio_channel),
      .rsp_tx_power(rsp_tx_power),
      .rsp_peer_count(rsp_peer_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side at random, except in the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watch both channels: note every byte transfer, check every result transfer
   always @(posedge clock) begin
      result_type seen;
      if (!reset) begin
         if (req_valid && req_ready) tracker.take_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            seen               = '0;
            seen.event_res     = event_type'(rsp_event_res);
            seen.data_byte     = rsp_data_byte;
            seen.last          = rsp_last;
            seen.src_mac       = rsp_src_mac;
            seen.rssi          = rsp_rssi;
            seen.data_length   = rsp_data_length;
            seen.crc_ok        = rsp_crc_ok;
            seen.modem_mac     = rsp_modem_mac;
            seen.long_range    = rsp_long_range;
            seen.radio_channel = rsp_radio_channel;
            seen.tx_power      = rsp_tx_power;
            seen.peer_count    = rsp_peer_count;
            tracker.check_result(seen);
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one byte, idling at random in front outside the calm stretch, and hold it until transferred
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
      calm = (sent_bytes >= CALM_FIRST && sent_bytes < CALM_LAST);
   endtask

   function automatic byte_q_t random_body(input int n);
      byte_q_t q;
      for (int k = 0; k < n; k++) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // Send sync, header and, for a legal length, the payload and its CRC byte
   task automatic send_frame(input logic [7:0] dir, input logic [15:0] len,
                             input byte_q_t body);
      logic [7:0] crc;
      crc = '0;
      send_byte(SYNC1_BYTE);
      send_byte(SYNC2_BYTE);
      send_byte(dir);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len != 16'd0 && len <= MAX_PAYLOAD_TB) begin
         foreach (body[k]) begin
            crc = tracker.fold_crc(crc, body[k]);
            send_byte(body[k]);
         end
         // corrupt the CRC now and then
         if ($urandom_range(0, 4) == 0) crc = crc ^ 8'($urandom_range(1, 255));
         send_byte(crc);
      end
   endtask

   task automatic status_frame(input int len);
      byte_q_t body;
      body = random_body(len);
      if ($urandom_range(0, 6) != 0) begin
         body[0] = STATUS_HDR0;
         if (len > 1) body[1] = STATUS_HDR1;
      end
      if (len > POS_MODE && $urandom_range(0, 1) == 1) body[POS_MODE] = MODE_LONG_RANGE;
      send_frame(DIR_STATUS, 16'(len), body);
   endtask

   initial begin
      byte_q_t     empty_body;
      int          pick;
      int          sel;
      int          len;
      logic [15:0] bad_len;
      logic [7:0]  b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: bytes while hunting, wrong second sync, zero length, short data frame
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC1_BYTE);
      send_byte(SYNC1_BYTE);
      send_frame(DIR_DATA, 16'd0, empty_body);
      send_frame(DIR_DATA, 16'd8,
                 '{8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h80, 8'hA5});

      // Largest legal frame, and one just above the limit
      send_frame(DIR_DATA, 16'(MAX_PAYLOAD_TB), random_body(MAX_PAYLOAD_TB));
      send_frame(DIR_DATA, 16'(MAX_PAYLOAD_TB + 1), empty_body);
      status_frame(12);

      // Random traffic, mostly well-formed frames
      while (sent_bytes < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            sel = $urandom_range(0, 19);
            if (sel < 16) len = $urandom_range(7, 24);
            else if (sel < 19) len = $urandom_range(1, 6);
            else len = $urandom_range(25, 60);
            send_frame(DIR_DATA, 16'(len), random_body(len));
         end else if (pick < 65) begin
            len = ($urandom_range(0, 4) != 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
            status_frame(len);
         end else if (pick < 75) begin
            len = $urandom_range(1, 16);
            send_frame(8'($urandom_range(0, 255)), 16'(len), random_body(len));
         end else if (pick < 85) begin
            sel = $urandom_range(0, 3);
            if (sel == 0) bad_len = 16'd0;
            else if (sel == 1) bad_len = 16'(MAX_PAYLOAD_TB + 1);
            else if (sel == 2) bad_len = 16'hFFFF;
            else bad_len = 16'($urandom_range(MAX_PAYLOAD_TB + 1, 65535));
            send_frame(8'($urandom_range(0, 255)), bad_len, empty_body);
         end else if (pick < 93) begin
            // broken sync: first byte right, second wrong
            b = 8'($urandom_range(0, 255));
            if (b == SYNC2_BYTE) b = SYNC1_BYTE;
            send_byte(SYNC1_BYTE);
            send_byte(b);
         end else begin
            // line noise that does not start a sync
            repeat ($urandom_range(1, 5)) begin
               b = 8'($urandom_range(0, 255));
               if (b == SYNC1_BYTE) b = ~b;
               send_byte(b);
            end
         end
      end
      req_valid <= 1'b0;

      // Let the last byte transfer be noted, drain outstanding results, then settle
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
